/* rtl/core/reassembly_gap_tracker_macros.svh */
// Assertion shorthands for the gap tracker. Each use expects clk and arst_n in scope.
`ifndef REASSEMBLY_GAP_TRACKER_MACROS_SVH
`define REASSEMBLY_GAP_TRACKER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RGT_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RGT_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/rgt_pkg.sv */
package rgt_pkg;

	// Result codes of one beat.
	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_NO_ROOM    = 2'd1,
		ST_TABLE_FULL = 2'd2,
		ST_OVERFLOW   = 2'd3
	} status_t;

	// Which piece of a gap the cut unit produces: the part below or above the range.
	typedef enum logic {
		SIDE_LO,
		SIDE_HI
	} side_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_READ,
		S_LO,
		S_HI,
		S_FREE,
		S_COMMIT,
		S_OUT
	} seq_state_t;

	// Configuration register indexes.
	localparam int CfgIdxW = 2;
	localparam logic [CfgIdxW-1:0] REG_EXPANDABLE     = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_MAX_LENGTH     = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_INITIAL_LENGTH = 2'd2;

	// Width of the offset and length fields.
	localparam int DataW = 32;

endpackage

/* rtl/core/reassembly_gap_tracker.sv */
// Reassembly gap tracker. Each input beat reports a received byte range
// [write_offset, write_offset + write_length) and yields one result beat with
// a status code, the fill level, the start of the final gap, the buffer length
// and the number of interior gaps. The range is cut out of every interior gap
// by one shared cut unit that walks the gap table one entry per read, spending
// the state S_LO on the piece below the range and S_HI on the piece above it.
// The next beat is accepted while the previous result waits on out_ready. The
// table lives in two banks: the walk writes the new table into the spare bank
// and a commit swaps banks, so a failed beat leaves all state untouched.
// Writing initial_length restarts tracking with a single free gap; the user
// must make configuration writes only while the block is idle, and the block
// itself does not enforce this.
`include "reassembly_gap_tracker_macros.svh"

module reassembly_gap_tracker
	import rgt_pkg::*;
#(
	parameter int MAX_GAPS    = 16,
	parameter int OFFSET_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [DataW-1:0]   cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [DataW-1:0]   write_offset,
	input  logic [DataW-1:0]   write_length,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic [DataW-1:0]   filled_to,
	output logic [DataW-1:0]   final_gap_start,
	output logic [DataW-1:0]   current_length,
	output logic [4:0]         open_gaps
);

	// Stored positions never exceed the offset limit nor the 32-bit field range.
	localparam int PosW = (OFFSET_BITS < DataW) ? OFFSET_BITS : DataW;
	localparam int IdxW = (MAX_GAPS > 1) ? $clog2(MAX_GAPS) : 1;
	localparam int CntW = $clog2(MAX_GAPS + 1);
	localparam int KW   = $clog2(2 * MAX_GAPS + 2);
	localparam logic [DataW:0] OfsLimit = (OFFSET_BITS > DataW) ? {(DataW + 1){1'b1}} :
		((33'd1 << OFFSET_BITS) - 33'd1);

	// Control state.
	seq_state_t      state_q, state_d;
	logic            expandable_q;
	logic [DataW-1:0] max_len_q;
	logic [PosW-1:0] len_q, fill_q, free_q;
	logic [CntW-1:0] count_q;
	logic            bank_q;
	logic            out_valid_q;

	// Per-item working registers.
	logic [DataW-1:0] ds_q;
	logic [DataW:0]  de_q;
	logic [PosW-1:0] new_len_q, new_free_q, min_q;
	logic [IdxW-1:0] idx_q;
	logic [KW-1:0]   k_q;
	status_t         status_q;

	// Output register.
	status_t         out_status_q;
	logic [PosW-1:0] out_fill_q, out_free_q, out_len_q;
	logic [CntW-1:0] out_count_q;

	// Sequencer controls.
	logic            rd_en;
	logic [IdxW-1:0] rd_idx;
	side_t           cut_side;
	logic            use_free;
	logic            idx_last;

	// Table and cut unit wiring.
	logic [PosW-1:0] rd_lo, rd_hi;
	logic [PosW-1:0] cut_lo, cut_hi, cut_min;
	logic [PosW-1:0] piece_lo, piece_hi;
	logic            cut_hit, cut_step, wr_en;

	// Range checks made once per item.
	logic            ovf_c, beyond_c, no_room_c, table_full_c;
	logic [PosW-1:0] new_free_c, init_sat_c;
	status_t         chk_status_c;

	assign ovf_c      = de_q > OfsLimit;
	assign beyond_c   = de_q > (DataW + 1)'(len_q);
	assign no_room_c  = beyond_c && (!expandable_q || (de_q > (DataW + 1)'(max_len_q)));
	assign new_free_c = (de_q > (DataW + 1)'(free_q)) ? PosW'(de_q) : free_q;
	assign table_full_c = k_q > KW'(MAX_GAPS);
	assign init_sat_c = ((DataW + 1)'(cfg_data) > OfsLimit) ? OfsLimit[PosW-1:0] :
		PosW'(cfg_data);

	always_comb begin
		if (ovf_c) begin
			chk_status_c = ST_OVERFLOW;
		end else if (no_room_c) begin
			chk_status_c = ST_NO_ROOM;
		end else begin
			chk_status_c = ST_OK;
		end
	end

	assign idx_last = (CntW'(idx_q) + CntW'(1)) == count_q;

	// Sequencer: next state and per-state controls.
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		rd_en    = 1'b0;
		rd_idx   = idx_q;
		cut_side = SIDE_LO;
		use_free = 1'b0;
		cut_step = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (chk_status_c != ST_OK) begin
					state_d = S_OUT;
				end else if (count_q == '0) begin
					state_d = S_FREE;
				end else begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				rd_en   = 1'b1;
				state_d = S_LO;
			end
			S_LO: begin
				cut_step = 1'b1;
				state_d  = S_HI;
			end
			S_HI: begin
				cut_side = SIDE_HI;
				cut_step = 1'b1;
				rd_idx   = idx_q + IdxW'(1);
				if (idx_last) begin
					state_d = S_FREE;
				end else begin
					rd_en   = 1'b1;
					state_d = S_LO;
				end
			end
			S_FREE: begin
				use_free = 1'b1;
				cut_step = 1'b1;
				state_d  = S_COMMIT;
			end
			S_COMMIT: begin
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Cut unit operands: a table entry, or the span from the final gap start up to the range.
	assign cut_lo = use_free ? free_q : rd_lo;
	assign cut_hi = use_free ? PosW'(ds_q) : rd_hi;

	rgt_cut #(
		.W(PosW)
	) u_cut (
		.side     (cut_side),
		.gap_lo   (cut_lo),
		.gap_hi   (cut_hi),
		.range_lo (PosW'(ds_q)),
		.range_hi (PosW'(de_q)),
		.min_in   (min_q),
		.hit      (cut_hit),
		.piece_lo (piece_lo),
		.piece_hi (piece_hi),
		.min_out  (cut_min)
	);

	// Pieces past the table depth are dropped; such an item fails at commit anyway.
	assign wr_en = cut_step && cut_hit && (k_q < KW'(MAX_GAPS));

	rgt_table #(
		.W     (PosW),
		.DEPTH (MAX_GAPS),
		.IdxW  (IdxW)
	) u_table (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_bank (bank_q),
		.rd_idx  (rd_idx),
		.rd_lo   (rd_lo),
		.rd_hi   (rd_hi),
		.wr_en   (wr_en),
		.wr_bank (!bank_q),
		.wr_idx  (k_q[IdxW-1:0]),
		.wr_lo   (piece_lo),
		.wr_hi   (piece_hi)
	);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Tracking state, configuration and commit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expandable_q <= 1'b0;
			max_len_q    <= '1;
			len_q        <= '0;
			fill_q       <= '0;
			free_q       <= '0;
			count_q      <= '0;
			bank_q       <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_EXPANDABLE: begin
						expandable_q <= cfg_data[0];
					end
					REG_MAX_LENGTH: begin
						max_len_q <= cfg_data;
					end
					REG_INITIAL_LENGTH: begin
						len_q   <= init_sat_c;
						fill_q  <= '0;
						free_q  <= '0;
						count_q <= '0;
					end
					default: begin
					end
				endcase
			end
			if ((state_q == S_COMMIT) && !table_full_c) begin
				bank_q  <= !bank_q;
				count_q <= CntW'(k_q);
				len_q   <= new_len_q;
				free_q  <= new_free_q;
				fill_q  <= min_q;
			end
		end
	end

	// Per-item working registers.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ds_q <= write_offset;
			de_q <= (DataW + 1)'(write_offset) + (DataW + 1)'(write_length);
		end
		case (state_q)
			S_CHECK: begin
				status_q   <= chk_status_c;
				new_len_q  <= beyond_c ? PosW'(de_q) : len_q;
				new_free_q <= new_free_c;
				min_q      <= new_free_c;
				idx_q      <= '0;
				k_q        <= '0;
			end
			S_LO, S_FREE: begin
				if (cut_hit) begin
					k_q <= k_q + KW'(1);
				end
				min_q <= cut_min;
			end
			S_HI: begin
				if (cut_hit) begin
					k_q <= k_q + KW'(1);
				end
				min_q <= cut_min;
				idx_q <= idx_q + IdxW'(1);
			end
			S_COMMIT: begin
				if (table_full_c) begin
					status_q <= ST_TABLE_FULL;
				end
			end
			default: begin
			end
		endcase
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_OUT) && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload, loaded from the committed state.
	always_ff @(posedge clk) begin
		if ((state_q == S_OUT) && (!out_valid_q || out_ready)) begin
			out_status_q <= status_q;
			out_fill_q   <= fill_q;
			out_free_q   <= free_q;
			out_len_q    <= len_q;
			out_count_q  <= count_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = out_status_q;
	assign filled_to       = DataW'(out_fill_q);
	assign final_gap_start = DataW'(out_free_q);
	assign current_length  = DataW'(out_len_q);
	assign open_gaps       = 5'(out_count_q);

	// Checks on the tracking logic.
	`RGT_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CntW'(MAX_GAPS), "gap count above table depth")
	`RGT_ASSERT_IMP(a_fill_order, out_valid && (status == ST_OK), filled_to <= final_gap_start, "fill level beyond final gap start")
	`RGT_ASSERT_NXT(a_full_keeps, (state_q == S_COMMIT) && table_full_c, $stable(bank_q) && $stable(count_q), "failed item changed the gap table")

endmodule

/* rtl/core/rgt_cut.sv */
module rgt_cut
	import rgt_pkg::*;
#(
	parameter int W = 32
) (
	input  side_t          side,
	input  logic [W-1:0]   gap_lo,
	input  logic [W-1:0]   gap_hi,
	input  logic [W-1:0]   range_lo,
	input  logic [W-1:0]   range_hi,
	input  logic [W-1:0]   min_in,
	output logic           hit,
	output logic [W-1:0]   piece_lo,
	output logic [W-1:0]   piece_hi,
	output logic [W-1:0]   min_out
);

	logic [W-1:0] hit_a, hit_b, sel_a, sel_b;
	logic         sel_lt;

	// Operand steering: the low side keeps [gap_lo, min(gap_hi, range_lo)),
	// the high side keeps [max(gap_lo, range_hi), gap_hi).
	always_comb begin
		if (side == SIDE_HI) begin
			hit_a = range_hi;
			hit_b = gap_hi;
			sel_a = range_hi;
			sel_b = gap_lo;
		end else begin
			hit_a = gap_lo;
			hit_b = range_lo;
			sel_a = gap_hi;
			sel_b = range_lo;
		end
	end

	assign hit    = hit_a < hit_b;
	assign sel_lt = sel_a < sel_b;

	// Piece bounds from the selection compare.
	always_comb begin
		if (side == SIDE_HI) begin
			piece_lo = sel_lt ? gap_lo : range_hi;
			piece_hi = gap_hi;
		end else begin
			piece_lo = gap_lo;
			piece_hi = sel_lt ? gap_hi : range_lo;
		end
	end

	// Running minimum of the piece starts, which becomes the fill level.
	assign min_out = (hit && (piece_lo < min_in)) ? piece_lo : min_in;

endmodule

/* rtl/core/rgt_table.sv */
module rgt_table
	import rgt_pkg::*;
#(
	parameter int W     = 32,
	parameter int DEPTH = 16,
	parameter int IdxW  = 4
) (
	input  logic            clk,
	input  logic            rd_en,
	input  logic            rd_bank,
	input  logic [IdxW-1:0] rd_idx,
	output logic [W-1:0]    rd_lo,
	output logic [W-1:0]    rd_hi,
	input  logic            wr_en,
	input  logic            wr_bank,
	input  logic [IdxW-1:0] wr_idx,
	input  logic [W-1:0]    wr_lo,
	input  logic [W-1:0]    wr_hi
);

	// Two banks of gap bounds: one holds the live table, the other takes the rebuilt one.
	logic [W-1:0] lo_mem [2][DEPTH];
	logic [W-1:0] hi_mem [2][DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			lo_mem[wr_bank][wr_idx] <= wr_lo;
			hi_mem[wr_bank][wr_idx] <= wr_hi;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_lo <= lo_mem[rd_bank][rd_idx];
			rd_hi <= hi_mem[rd_bank][rd_idx];
		end
	end

endmodule
